### rtl/etc_pkg.sv
// Shared types, constants and helpers for the epoch seconds to calendar converter.
package etc_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_EPOCH_YEAR    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPOCH_WEEKDAY = 4'd1;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [11:0] EPOCH_YEAR_RST    = 12'd1970;
  localparam logic [2:0]  EPOCH_WEEKDAY_RST = 3'd4;

  // Time-of-day split by reciprocal multiply: q = (x * RECIP) >> shift
  localparam logic [31:0] RECIP_60 = 32'h8888_8889;  // exact for any 32-bit x, shift 37
  localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;  // exact for x below 2^21, shift 36
  localparam logic [6:0] SECS_PER_MIN  = 7'd60;
  localparam logic [6:0] MINS_PER_HOUR = 7'd60;
  localparam logic [6:0] HOURS_PER_DAY = 7'd24;

  localparam logic [15:0] DAYS_PER_YEAR = 16'd365;
  localparam logic [15:0] DAYS_PER_LEAP = 16'd366;
  localparam logic [11:0] YEARS_400     = 12'd400;
  localparam logic [11:0] YEARS_100     = 12'd100;
  localparam logic [8:0]  LAST_MOD400   = 9'd399;
  localparam logic [6:0]  LAST_MOD100   = 7'd99;
  localparam logic [3:0]  MON_FEB       = 4'd1;
  localparam logic [3:0]  MON_DEC       = 4'd11;
  localparam logic [4:0]  FEB_DAYS      = 5'd28;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MOD400,
    ST_MOD100,
    ST_YEAR,
    ST_MONTH,
    ST_FINISH
  } etc_state_e;

  typedef enum logic [1:0] {
    PASS_SEC,
    PASS_MIN,
    PASS_HOUR
  } etc_pass_e;

  // Days in a month of a common year, month 0 is January
  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] len;
    case (mon)
      4'd1:                     len = FEB_DAYS;
      4'd3, 4'd5, 4'd8, 4'd10:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

  // Reduce a 6-bit value modulo 7
  function automatic logic [2:0] mod7(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    if (r >= 6'd56) r = r - 6'd56;
    if (r >= 6'd28) r = r - 6'd28;
    if (r >= 6'd14) r = r - 6'd14;
    if (r >= 6'd7)  r = r - 6'd7;
    return r[2:0];
  endfunction

endpackage

### rtl/etc_intf.sv
// Handshake channel interfaces: time input, calendar result, configuration write.
interface etc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_seconds;
  modport source (output valid, output time_seconds, input ready);
  modport sink   (input valid, input time_seconds, output ready);
endinterface

interface etc_res_if;
  logic       valid;
  logic       ready;
  logic [5:0] seconds;
  logic [5:0] minutes;
  logic [4:0] hours;
  logic [2:0] weekday;
  logic [6:0] year_two_digit;
  logic [3:0] month_number;
  logic [4:0] day_of_month;
  modport source (output valid, output seconds, output minutes, output hours,
                  output weekday, output year_two_digit, output month_number,
                  output day_of_month, input ready);
  modport sink   (input valid, input seconds, input minutes, input hours,
                  input weekday, input year_two_digit, input month_number,
                  input day_of_month, output ready);
endinterface

interface etc_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [11:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/epoch_seconds_to_calendar_core.sv
// Sequence per input beat: the time-of-day split (multiply, then fix-up, for each of the
// seconds, minutes and hours passes), reduction of the epoch year mod 400 and mod 100 by
// repeated subtraction, a walk over the years, then over the months, then the result load.
// One beat in flight; the next is taken the cycle after the result load, and a result
// held by a stalled sink keeps the sequencer waiting. Reset (async, active low) clears
// sequencer and result valid, loads epoch 1970 / weekday 4. Config writes always accepted.
module epoch_seconds_to_calendar_core
  import etc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  etc_in_if.sink          in_i,
  etc_res_if.source       res_o,
  etc_cfg_if.sink         cfg_i
);

  // Configuration registers
  logic [11:0] epoch_year_q;
  logic [2:0]  epoch_weekday_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_year_q    <= EPOCH_YEAR_RST;
      epoch_weekday_q <= EPOCH_WEEKDAY_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_EPOCH_YEAR:    epoch_year_q    <= cfg_i.data;
        REG_EPOCH_WEEKDAY: epoch_weekday_q <= cfg_i.data[2:0];
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  // Sequencer and datapath
  etc_state_e  state_q, state_d;
  etc_pass_e   pass_q, pass_d;
  logic        mul_done_q, mul_done_d;  // product of this pass sits in prod_q
  logic [31:0] quo_q, quo_d;       // dividend of the current pass
  logic [63:0] prod_q, prod_d;     // dividend times reciprocal
  logic [5:0]  sec_q, sec_d;
  logic [5:0]  min_q, min_d;
  logic [4:0]  hour_q, hour_d;
  logic [15:0] days_q, days_d;     // days left to place
  logic [11:0] yr_q, yr_d;         // scratch for epoch year mod 400 / mod 100
  logic [8:0]  m400_q, m400_d;     // current year mod 400
  logic [6:0]  m100_q, m100_d;     // current year mod 100
  logic [2:0]  wd_q, wd_d;         // weekday of the first day still unplaced
  logic [3:0]  mon_q, mon_d;       // 0-based month

  // Result register
  logic        out_valid_q, out_valid_d;
  logic        out_load;
  logic [5:0]  out_sec_q;
  logic [5:0]  out_min_q;
  logic [4:0]  out_hour_q;
  logic [2:0]  out_wday_q;
  logic [6:0]  out_year_q;
  logic [3:0]  out_mon_q;
  logic [4:0]  out_day_q;

  // Shared divide-by-constant unit
  logic [31:0] div_rcp;
  logic [6:0]  div_dvs;
  logic [31:0] div_quo;
  logic [31:0] div_rem_w;
  logic [5:0]  div_rem;

  logic        leap;
  logic [4:0]  mlen;

  always_comb begin
    case (pass_q)
      PASS_SEC: begin
        div_dvs = SECS_PER_MIN;
        div_rcp = RECIP_60;
      end
      PASS_MIN: begin
        div_dvs = MINS_PER_HOUR;
        div_rcp = RECIP_60;
      end
      PASS_HOUR: begin
        div_dvs = HOURS_PER_DAY;
        div_rcp = RECIP_24;
      end
      default: begin
        div_dvs = SECS_PER_MIN;
        div_rcp = RECIP_60;
      end
    endcase
    // quotient from the registered product, remainder by back-multiply
    div_quo   = (pass_q == PASS_HOUR) ? {4'd0, prod_q[63:36]} : {5'd0, prod_q[63:37]};
    div_rem_w = quo_q - (div_quo * {25'd0, div_dvs});
    div_rem   = div_rem_w[5:0];
  end

  // Gregorian rule on the tracked residues; 400 is a multiple of 4
  assign leap = (m400_q == 9'd0) || ((m100_q != 7'd0) && (m400_q[1:0] == 2'd0));
  assign mlen = month_len(mon_q) + 5'((mon_q == MON_FEB) && leap);

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    mul_done_d  = mul_done_q;
    quo_d       = quo_q;
    prod_d      = prod_q;
    sec_d       = sec_q;
    min_d       = min_q;
    hour_d      = hour_q;
    days_d      = days_q;
    yr_d        = yr_q;
    m400_d      = m400_q;
    m100_d      = m100_q;
    wd_d        = wd_q;
    mon_d       = mon_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !res_o.ready;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          quo_d      = in_i.time_seconds;
          mul_done_d = 1'b0;
          pass_d     = PASS_SEC;
          state_d    = ST_DIV;
        end
      end

      ST_DIV: begin
        if (!mul_done_q) begin
          prod_d     = {32'd0, quo_q} * {32'd0, div_rcp};
          mul_done_d = 1'b1;
        end else begin
          mul_done_d = 1'b0;
          case (pass_q)
            PASS_SEC: begin
              sec_d  = div_rem;
              quo_d  = div_quo;
              pass_d = PASS_MIN;
            end
            PASS_MIN: begin
              min_d  = div_rem;
              quo_d  = div_quo;
              pass_d = PASS_HOUR;
            end
            default: begin
              hour_d  = div_rem[4:0];
              days_d  = div_quo[15:0];
              yr_d    = epoch_year_q;
              wd_d    = (epoch_weekday_q == 3'd7) ? 3'd0 : epoch_weekday_q;
              state_d = ST_MOD400;
            end
          endcase
        end
      end

      ST_MOD400: begin
        if (yr_q >= YEARS_400) begin
          yr_d = yr_q - YEARS_400;
        end else begin
          m400_d  = yr_q[8:0];
          state_d = ST_MOD100;
        end
      end

      ST_MOD100: begin
        if (yr_q >= YEARS_100) begin
          yr_d = yr_q - YEARS_100;
        end else begin
          m100_d  = yr_q[6:0];
          state_d = ST_YEAR;
        end
      end

      ST_YEAR: begin
        // Last day of a leap year stays in that year
        if ((days_q >= DAYS_PER_YEAR) && !(leap && (days_q == DAYS_PER_YEAR))) begin
          days_d = days_q - (leap ? DAYS_PER_LEAP : DAYS_PER_YEAR);
          wd_d   = mod7({3'd0, wd_q} + (leap ? 6'd2 : 6'd1));
          m400_d = (m400_q == LAST_MOD400) ? 9'd0 : m400_q + 9'd1;
          m100_d = (m100_q == LAST_MOD100) ? 7'd0 : m100_q + 7'd1;
        end else begin
          mon_d   = '0;
          state_d = ST_MONTH;
        end
      end

      ST_MONTH: begin
        if ((mon_q < MON_DEC) && (days_q >= {11'd0, mlen})) begin
          days_d = days_q - {11'd0, mlen};
          wd_d   = mod7({3'd0, wd_q} + {1'b0, mlen});
          mon_d  = mon_q + 4'd1;
        end else begin
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!out_valid_q || res_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= PASS_SEC;
      mul_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      mul_done_q  <= mul_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    prod_q <= prod_d;
    sec_q  <= sec_d;
    min_q  <= min_d;
    hour_q <= hour_d;
    days_q <= days_d;
    yr_q   <= yr_d;
    m400_q <= m400_d;
    m100_q <= m100_d;
    wd_q   <= wd_d;
    mon_q  <= mon_d;
    if (out_load) begin
      out_sec_q  <= sec_q;
      out_min_q  <= min_q;
      out_hour_q <= hour_q;
      // remaining days are under 31 here
      out_wday_q <= mod7({3'd0, wd_q} + {1'b0, days_q[4:0]});
      out_year_q <= m100_q;
      out_mon_q  <= mon_q + 4'd1;
      out_day_q  <= days_q[4:0] + 5'd1;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.seconds        = out_sec_q;
  assign res_o.minutes        = out_min_q;
  assign res_o.hours          = out_hour_q;
  assign res_o.weekday        = out_wday_q;
  assign res_o.year_two_digit = out_year_q;
  assign res_o.month_number   = out_mon_q;
  assign res_o.day_of_month   = out_day_q;

endmodule
